FILE: hdl/spring_force_3d_defines.svh
// Assertion macros shared by the spring force block.
`ifndef SPRING_FORCE_3D_DEFINES_SVH
`define SPRING_FORCE_3D_DEFINES_SVH

// Checks a property on the rising clock edge, with reset held off.
`define SF3D_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that one condition implies another in the same cycle.
`define SF3D_ASSERT_IMPL(lbl, a, b, msg) \
	`SF3D_ASSERT(lbl, (a) |-> (b), msg)

`endif

FILE: hdl/sf3d_pkg.sv
// ----------------------------------------------------------------------------
// sf3d_pkg
// Types and constants shared by the spring force pipeline.
// ----------------------------------------------------------------------------
package sf3d_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_USE_ANCHOR      = 3'd0,
		REG_ANCHOR_X        = 3'd1,
		REG_ANCHOR_Y        = 3'd2,
		REG_ANCHOR_Z        = 3'd3,
		REG_REST_LENGTH     = 3'd4,
		REG_SPRING_CONSTANT = 3'd5
	} sf3d_reg_t;

	localparam logic [30:0] UNITY    = 31'(64'd1 << FRAC_BITS);
	localparam logic [31:0] POS_CAP  = 32'h7FFF_FFFF;
	localparam logic [31:0] NEG_CAP  = 32'h8000_0000;

	// Per-item side data that rides along with the square root.
	typedef struct packed {
		logic [2:0]       dneg;
		logic [2:0][31:0] dm;
		logic             zero;
	} sf3d_side_t;

	// Per-component side data that rides along with a divider.
	typedef struct packed {
		logic neg;
		logic zero;
	} sf3d_tag_t;

endpackage

FILE: hdl/sf3d_sqrt.sv
// ----------------------------------------------------------------------------
// sf3d_sqrt
// Pipelined integer square root of a 66-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module sf3d_sqrt import sf3d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [65:0] in_n,
	input  sf3d_side_t  in_side,
	output logic        out_valid,
	output logic [32:0] out_root,
	output sf3d_side_t  out_side
);

	localparam int STAGES = 33;

	logic              vld_s  [0:STAGES];
	logic [34:0]       rem_s  [0:STAGES];
	logic [32:0]       root_s [0:STAGES];
	logic [65:0]       n_s    [0:STAGES];
	sf3d_side_t        side_s [0:STAGES];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign n_s[0]    = in_n;
	assign side_s[0] = in_side;

	for (genvar i = 1; i <= STAGES; i++) begin : g_stage
		logic [36:0] cur;
		logic [36:0] trial;
		logic        take;

		// Bring down the next two bits and try appending a one to the root.
		assign cur   = {rem_s[i-1], n_s[i-1][65:64]};
		assign trial = {2'b00, root_s[i-1], 2'b01};
		assign take  = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= take ? 35'(cur - trial) : cur[34:0];
				root_s[i] <= {root_s[i-1][31:0], take};
				n_s[i]    <= {n_s[i-1][63:0], 2'b00};
				side_s[i] <= side_s[i-1];
			end
		end
	end

	assign out_valid = vld_s[STAGES];
	assign out_root  = root_s[STAGES];
	assign out_side  = side_s[STAGES];

endmodule

FILE: hdl/sf3d_div.sv
// ----------------------------------------------------------------------------
// sf3d_div
// Pipelined restoring divider, 64-bit dividend by 33-bit divisor, giving a
// 32-bit quotient and a flag for quotients of 2^32 and more.
// ----------------------------------------------------------------------------
module sf3d_div import sf3d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [63:0] in_num,
	input  logic [32:0] in_den,
	input  sf3d_tag_t   in_tag,
	output logic        out_valid,
	output logic [31:0] out_quot,
	output logic        out_ovf,
	output sf3d_tag_t   out_tag
);

	localparam int QBITS = 32;

	logic        vld_s [0:QBITS];
	logic [63:0] rem_s [0:QBITS];
	logic [32:0] den_s [0:QBITS];
	logic [31:0] quo_s [0:QBITS];
	logic        ovf_s [0:QBITS];
	sf3d_tag_t   tag_s [0:QBITS];

	// The first stage only decides whether the quotient fits in 32 bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= in_num;
			den_s[0] <= in_den;
			quo_s[0] <= '0;
			ovf_s[0] <= {32'd0, in_num} >= {in_den, 64'd0} >> 32;
			tag_s[0] <= in_tag;
		end
	end

	for (genvar i = 1; i <= QBITS; i++) begin : g_stage
		logic [64:0] den_sh;
		logic        take;

		assign den_sh = 65'(den_s[i-1]) << (QBITS - i);
		assign take   = {1'b0, rem_s[i-1]} >= den_sh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= take ? rem_s[i-1] - den_sh[63:0] : rem_s[i-1];
				den_s[i] <= den_s[i-1];
				quo_s[i] <= {quo_s[i-1][30:0], take};
				ovf_s[i] <= ovf_s[i-1];
				tag_s[i] <= tag_s[i-1];
			end
		end
	end

	assign out_valid = vld_s[QBITS];
	assign out_quot  = quo_s[QBITS];
	assign out_ovf   = ovf_s[QBITS];
	assign out_tag   = tag_s[QBITS];

endmodule

FILE: hdl/spring_force_3d.sv
// ----------------------------------------------------------------------------
// spring_force_3d
// Hooke spring force between a particle and a partner or a fixed anchor.
// ----------------------------------------------------------------------------
// The block takes one position pair per cycle while the output side does not
// stall, and returns one force vector per input. The pipeline is made of the
// 33-stage square root and the 33-stage dividers, with eight further stages
// for the offset, the squares, the sum, the stretch, the magnitude, the
// products and the output register. A stall on the output freezes the whole
// pipeline, and s_tready falls with it.
// Configuration is written through cfg_we, cfg_index and cfg_data and must
// only change while no transaction is in flight.
// ----------------------------------------------------------------------------
`include "spring_force_3d_defines.svh"

module spring_force_3d import sf3d_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// pos_x, pos_y, pos_z, other_x, other_y, other_z
	input  logic [191:0]          s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// force_x, force_y, force_z
	output logic [95:0]           m_tdata,
	// zero_offset
	output logic [0:0]            m_tuser
);

	logic        use_anchor_q;
	logic [31:0] anchor_q [3];
	logic [30:0] rest_length_q;
	logic [30:0] spring_constant_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_anchor_q      <= 1'b0;
			anchor_q[0]       <= '0;
			anchor_q[1]       <= '0;
			anchor_q[2]       <= '0;
			rest_length_q     <= UNITY;
			spring_constant_q <= UNITY;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_USE_ANCHOR:      use_anchor_q      <= cfg_data[0];
				REG_ANCHOR_X:        anchor_q[0]       <= cfg_data[31:0];
				REG_ANCHOR_Y:        anchor_q[1]       <= cfg_data[31:0];
				REG_ANCHOR_Z:        anchor_q[2]       <= cfg_data[31:0];
				REG_REST_LENGTH:     rest_length_q     <= cfg_data[30:0];
				REG_SPRING_CONSTANT: spring_constant_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	logic en;
	logic out_valid_q;

	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;

	// Offset, squares and sum of squares.
	logic              vld_s1, vld_s2, vld_s3;
	logic signed [32:0] d_s1 [3];
	logic [63:0]       sq_s2 [3];
	sf3d_side_t        side_s2, side_s3;
	logic [65:0]       n_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_comp
		logic [31:0] pos, oth, q;
		logic [31:0] dabs;

		assign pos  = s_tdata[32*c +: 32];
		assign oth  = s_tdata[96 + 32*c +: 32];
		assign q    = use_anchor_q ? anchor_q[c] : oth;
		assign dabs = d_s1[c][32] ? 32'(-d_s1[c]) : d_s1[c][31:0];

		always_ff @(posedge clk) begin
			if (en) begin
				d_s1[c]         <= $signed({pos[31], pos}) - $signed({q[31], q});
				sq_s2[c]        <= 64'(dabs) * 64'(dabs);
				side_s2.dneg[c] <= d_s1[c][32];
				side_s2.dm[c]   <= dabs;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.zero <= 1'b0;
			n_s3         <= 66'(sq_s2[0]) + 66'(sq_s2[1]) + 66'(sq_s2[2]);
			side_s3.dneg <= side_s2.dneg;
			side_s3.dm   <= side_s2.dm;
			side_s3.zero <= (sq_s2[0] == '0) && (sq_s2[1] == '0) && (sq_s2[2] == '0);
		end
	end

	logic        sq_valid;
	logic [32:0] sq_len;
	sf3d_side_t  sq_side;

	sf3d_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s3),
		.in_n      (n_s3),
		.in_side   (side_s3),
		.out_valid (sq_valid),
		.out_root  (sq_len),
		.out_side  (sq_side)
	);

	// Stretch, magnitude and the three numerators.
	logic        vld_s4, vld_s5, vld_s6, vld_s7;
	logic [32:0] a_s4;
	logic        aneg_s4, aneg_s5, aneg_s6;
	logic [32:0] len_s4, len_s5, len_s6, len_s7;
	sf3d_side_t  side_s4, side_s5, side_s6, side_s7;
	logic [63:0] km_s5;
	logic [31:0] mmag_s6;
	logic [63:0] num_s7 [3];
	sf3d_tag_t   tag_s7 [3];
	logic [63:0] km_sh;

	assign km_sh = km_s5 >> FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s4 <= sq_valid;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			aneg_s4 <= sq_len < 33'(rest_length_q);
			a_s4    <= (sq_len < 33'(rest_length_q)) ? 33'(rest_length_q) - sq_len
			                                         : sq_len - 33'(rest_length_q);
			len_s4  <= sq_len;
			side_s4 <= sq_side;

			km_s5   <= 64'(spring_constant_q) * 64'(a_s4);
			aneg_s5 <= aneg_s4;
			len_s5  <= len_s4;
			side_s5 <= side_s4;

			if (aneg_s5) begin
				mmag_s6 <= (km_sh > 64'(NEG_CAP)) ? NEG_CAP : km_sh[31:0];
			end else begin
				mmag_s6 <= (km_sh > 64'(POS_CAP)) ? POS_CAP : km_sh[31:0];
			end
			aneg_s6 <= aneg_s5;
			len_s6  <= len_s5;
			side_s6 <= side_s5;

			len_s7  <= len_s6;
			side_s7 <= side_s6;
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_num
		always_ff @(posedge clk) begin
			if (en) begin
				num_s7[c]      <= 64'(mmag_s6) * 64'(side_s6.dm[c]);
				tag_s7[c].neg  <= aneg_s6 == side_s6.dneg[c];
				tag_s7[c].zero <= side_s6.zero;
			end
		end
	end

	logic        dv_valid [3];
	logic [31:0] dv_quot  [3];
	logic        dv_ovf   [3];
	sf3d_tag_t   dv_tag   [3];

	for (genvar c = 0; c < 3; c++) begin : g_div
		sf3d_div u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (vld_s7),
			.in_num    (num_s7[c]),
			.in_den    (len_s7),
			.in_tag    (tag_s7[c]),
			.out_valid (dv_valid[c]),
			.out_quot  (dv_quot[c]),
			.out_ovf   (dv_ovf[c]),
			.out_tag   (dv_tag[c])
		);
	end

	// Output register: saturation and the zero-length case.
	logic [31:0] force_q [3];
	logic        zero_q;

	function automatic logic [31:0] sat_force(input logic [31:0] quot, input logic ovf,
	                                          input sf3d_tag_t tag);
		logic [31:0] mag;
		mag = quot;
		if (tag.zero || (!ovf && quot == '0)) begin
			return '0;
		end
		if (tag.neg) begin
			if (ovf || mag > NEG_CAP) mag = NEG_CAP;
			return 32'(-mag);
		end
		if (ovf || mag > POS_CAP) mag = POS_CAP;
		return mag;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_valid[0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				force_q[c] <= sat_force(dv_quot[c], dv_ovf[c], dv_tag[c]);
			end
			zero_q <= dv_tag[0].zero;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {force_q[2], force_q[1], force_q[0]};
	assign m_tuser  = zero_q;

	`SF3D_ASSERT_IMPL(a_zero_force, m_tvalid && m_tuser[0], m_tdata == '0, "zero offset with nonzero force")
	`SF3D_ASSERT_IMPL(a_zero_len, sq_valid && sq_side.zero, sq_len == '0, "zero offset with nonzero length")
	`SF3D_ASSERT_IMPL(a_stall, !s_tready, m_tvalid && !m_tready, "input stalled without output stall")

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking test of the spring force pipeline. Each position pair sent in
// is run through a predictor of the fixed-point Hooke force, and every force
// vector that comes out is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench import sf3d_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 74;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [31:0] fz;
		logic [31:0] fy;
		logic [31:0] fx;
		logic        zflag;
	} force_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [191:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic [0:0] m_tuser;

	// Predictor copy of the registers.
	logic        anchored;
	logic [31:0] anc [3];
	logic [30:0] rest_len;
	logic [30:0] stiffness;

	force_t expected_forces [$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit sink_random = 1'b0;
	bit src_random = 1'b0;
	int hold_cycles = 0;
	bit done = 1'b0;

	spring_force_3d uut (.*);

	always #6 clk = ~clk;

	function automatic logic [31:0] saturate(bit neg, logic [63:0] mag);
		if (neg) begin
			if (mag > 64'h8000_0000) mag = 64'h8000_0000;
			return 32'(-mag);
		end
		if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
		return mag[31:0];
	endfunction

	function automatic force_t spring_force(logic [191:0] pk);
		force_t r;
		logic signed [32:0] d [3];
		logic [32:0] dm [3];
		logic [67:0] sumsq;
		logic [33:0] len, c;
		logic [34:0] a;
		logic [65:0] kp;
		logic [63:0] mmag;
		logic [96:0] prod;
		logic signed [31:0] p, q;
		bit aneg;
		sumsq = '0;
		for (int i = 0; i < 3; i++) begin
			p = pk[32*i +: 32];
			q = anchored ? anc[i] : pk[96 + 32*i +: 32];
			d[i] = 33'(p) - 33'(q);
			dm[i] = d[i][32] ? 33'(-d[i]) : d[i];
			sumsq += 68'(dm[i]) * 68'(dm[i]);
		end
		r = '0;
		if (sumsq == 0) begin
			r.zflag = 1'b1;
			return r;
		end
		len = '0;
		for (int b = 33; b >= 0; b--) begin
			c = len | (34'd1 << b);
			if (68'(c) * 68'(c) <= sumsq) len = c;
		end
		aneg = len < rest_len;
		a = aneg ? 35'(rest_len) - 35'(len) : 35'(len) - 35'(rest_len);
		kp = (66'(stiffness) * 66'(a)) >> FRAC_BITS;
		mmag = aneg ? (kp > 66'h8000_0000 ? 64'h8000_0000 : 64'(kp))
		            : (kp > 66'h7FFF_FFFF ? 64'h7FFF_FFFF : 64'(kp));
		for (int i = 0; i < 3; i++) begin
			prod = (97'(mmag) * 97'(dm[i])) / 97'(len);
			p = prod == 0 ? 32'd0
			    : saturate(!(aneg != d[i][32]), prod > 97'hFFFF_FFFF ? 64'hFFFF_FFFF : 64'(prod));
			if (i == 0) r.fx = p; else if (i == 1) r.fy = p; else r.fz = p;
		end
		return r;
	endfunction

	task automatic write_reg(sf3d_reg_t idx, logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_USE_ANCHOR:      anchored = value[0];
			REG_ANCHOR_X:        anc[0] = value;
			REG_ANCHOR_Y:        anc[1] = value;
			REG_ANCHOR_Z:        anc[2] = value;
			REG_REST_LENGTH:     rest_len = value[30:0];
			REG_SPRING_CONSTANT: stiffness = value[30:0];
			default: ;
		endcase
	endtask

	// The valid is left high after a transaction so that the next item can
	// follow directly; drain and the idle gap take it down.
	task automatic send_positions(logic [191:0] pk);
		if (src_random && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pk;
		expected_forces.push_back(spring_force(pk));
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (expected_forces.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord;
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
			2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
		endcase
	endfunction

	function automatic logic [191:0] rand_item;
		logic [191:0] pk;
		for (int i = 0; i < 6; i++) pk[32*i +: 32] = rand_coord();
		if ($urandom_range(0, 15) == 0) pk[191:96] = pk[95:0];
		return pk;
	endfunction

	task automatic test_directed;
		logic [31:0] ext [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
		send_positions('0);
		send_positions({96'h0, 32'h0, 32'h0, 32'h0002_0000});
		send_positions({96'h0, 32'h0, 32'h0, 32'h0000_8000});
		send_positions({96'h0, 32'h0, 32'h0, 32'h0001_0000});
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				send_positions({{3{ext[j]}}, {3{ext[i]}}});
		drain();
		write_reg(REG_SPRING_CONSTANT, 32'h7FFF_FFFF);
		write_reg(REG_REST_LENGTH, 32'h0);
		send_positions({{3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}});
		send_positions({96'h0, 32'h3, 32'h1, 32'h7FFF_FFFF});
		drain();
	endtask

	task automatic test_random_partner(int n);
		for (int k = 0; k < n; k++) send_positions(rand_item());
		drain();
	endtask

	task automatic test_anchor;
		write_reg(REG_USE_ANCHOR, 32'h1);
		write_reg(REG_ANCHOR_X, rand_coord());
		write_reg(REG_ANCHOR_Y, rand_coord());
		write_reg(REG_ANCHOR_Z, 32'h8000_0000);
		send_positions({96'h0, 32'h8000_0000, anc[1], anc[0]});
		for (int k = 0; k < 200; k++) send_positions(rand_item());
		drain();
		write_reg(REG_USE_ANCHOR, 32'h0);
	endtask

	// The sink holds off long enough for the pipeline to fill and stall.
	// The hold is armed away from the rising edge so the sink cannot miss it.
	task automatic test_backpressure;
		@(negedge clk);
		hold_cycles = 300;
		@(posedge clk);
		for (int k = 0; k < 150; k++) send_positions(rand_item());
		drain();
	endtask

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else if (sink_random && $urandom_range(0, 5) == 0) begin
			hold_cycles <= $urandom_range(1, 19);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		force_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata, m_tuser[0]};
			if (expected_forces.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected force vector %h", got);
			end else begin
				want = expected_forces.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"force mismatch: expected x=%h y=%h z=%h zero=%b,",
						          " got x=%h y=%h z=%h zero=%b"},
						         want.fx, want.fy, want.fz, want.zflag,
						         got.fx, got.fy, got.fz, got.zflag);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || done || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		anchored = 1'b0;
		anc = '{32'h0, 32'h0, 32'h0};
		rest_len = UNITY;
		stiffness = UNITY;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		write_reg(REG_REST_LENGTH, 32'h0001_8000);
		write_reg(REG_SPRING_CONSTANT, 32'h0000_4000);
		sink_random = 1'b1;
		src_random = 1'b1;
		test_random_partner(400);
		test_anchor();
		write_reg(REG_REST_LENGTH, 32'h7FFF_FFFF);
		write_reg(REG_SPRING_CONSTANT, 32'h0);
		test_random_partner(50);
		write_reg(REG_SPRING_CONSTANT, 32'h0003_0000);
		test_backpressure();
		write_reg(REG_REST_LENGTH, 32'h0);
		write_reg(REG_SPRING_CONSTANT, 32'h7FFF_FFFF);
		sink_random = 1'b0;
		src_random = 1'b0;
		test_random_partner(380);
		done = 1'b1;
		if (mismatches == 0 && expected_forces.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

FILE: spring_force_3d.f
+incdir+hdl
hdl/sf3d_pkg.sv
hdl/sf3d_sqrt.sv
hdl/sf3d_div.sv
hdl/spring_force_3d.sv
sim/testbench.sv
